/* rtl/core/pse_pkg.sv */
`default_nettype none

package pse_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned DEPTH_W = 8;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_END  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_UNDER = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC
   } seq_state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_RUN,
      ALU_FIX
   } alu_state_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/pse_if.sv */
`default_nettype none

interface pse_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  operation;
   logic signed [31:0] number;

   modport source (output valid, output operation, output number, input ready);
   modport sink   (input valid, input operation, input number, output ready);
endinterface

interface pse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] top_value;
   logic        [1:0]  status;
   logic        [7:0]  stack_depth;
   logic               final_res;

   modport source (output valid, output top_value, output status, output stack_depth,
                   output final_res, input ready);
   modport sink   (input valid, input top_value, input status, input stack_depth,
                   input final_res, output ready);
endinterface

`default_nettype wire

/* rtl/core/pse_ram.sv */
`default_nettype none

module pse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/pse_alu.sv */
`default_nettype none

module pse_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pse_pkg::alu_cmd_type  cmd,
   input  wire logic [31:0]           a,
   input  wire logic [31:0]           b,
   output      pse_pkg::alu_rsp_type  rsp
);

   import pse_pkg::*;

   alu_state_type state_ff, state_in;
   op_type        op_ff, op_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   q_ff, q_in;
   logic [31:0]   m_ff, m_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic [31:0]   result_ff, result_in;

   logic [33:0]   add_x;
   logic [33:0]   add_y;
   logic          add_cin;
   logic [33:0]   sum;
   logic [31:0]   abs_a;
   logic [31:0]   abs_b;

   assign abs_a = a[31] ? (~a + 32'd1) : a;
   assign abs_b = b[31] ? (~b + 32'd1) : b;
   assign sum   = add_x + add_y + {33'd0, add_cin};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      m_ff      <= m_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      m_in      = m_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      add_x     = '0;
      add_y     = '0;
      add_cin   = 1'b0;
      case (state_ff)
         ALU_IDLE: begin
            add_x = {2'b00, a};
            if (cmd.op == OP_SUB) begin
               add_y   = ~{2'b00, b};
               add_cin = 1'b1;
            end else begin
               add_y = {2'b00, b};
            end
            if (cmd.start) begin
               op_in  = cmd.op;
               acc_in = '0;
               cnt_in = '0;
               case (cmd.op)
                  OP_MUL: begin
                     m_in     = a;
                     q_in     = b;
                     neg_in   = 1'b0;
                     state_in = ALU_RUN;
                  end
                  OP_DIV: begin
                     m_in     = abs_b;
                     q_in     = abs_a;
                     neg_in   = a[31] ^ b[31];
                     state_in = ALU_RUN;
                  end
                  default: begin
                     result_in = sum[31:0];
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         ALU_RUN: begin
            if (op_ff == OP_MUL) begin
               add_x  = {2'b00, acc_ff[30:0], 1'b0};
               add_y  = q_ff[31] ? {2'b00, m_ff} : '0;
               acc_in = sum[31:0];
               q_in   = {q_ff[30:0], 1'b0};
            end else begin
               add_x   = {1'b0, acc_ff, q_ff[31]};
               add_y   = ~{2'b00, m_ff};
               add_cin = 1'b1;
               if (!sum[33]) begin
                  acc_in = sum[31:0];
                  q_in   = {q_ff[30:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[30:0], q_ff[31]};
                  q_in   = {q_ff[30:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ALU_FIX;
            end
         end
         ALU_FIX: begin
            if (op_ff == OP_MUL) begin
               add_x = {2'b00, acc_ff};
            end else if (neg_ff) begin
               add_y   = {2'b00, ~q_ff};
               add_cin = 1'b1;
            end else begin
               add_y = {2'b00, q_ff};
            end
            result_in = sum[31:0];
            done_in   = 1'b1;
            state_in  = ALU_IDLE;
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

`default_nettype wire

/* rtl/core/postfix_stack_evaluator_top.sv */
`default_nettype none

// Postfix integer expression evaluator. Each request beat carries one token: a
// number to push, an operator that replaces the two top entries by their result,
// or an end mark that reports and clears the stack. Every token yields exactly one
// response beat. The top entry lives in a register and the rest of the stack in a
// RAM with one read and one write port, so an operator costs one RAM read. Push,
// end, faulted tokens and unknown codes respond in the cycle after acceptance. Add and
// subtract pass through the sequencer's read state and the registered result of the
// shared arithmetic unit before they respond, and multiply and divide also run its
// 32-step shift-add and shift-subtract loop. A new request is taken only while the
// sequencer is idle and the response register is free or being emptied. No clearing
// pass is needed after reset.
module postfix_stack_evaluator_top #(
   parameter int unsigned STACK_DEPTH = 128
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pse_req_if.sink    req_bus,
   pse_rsp_if.source  rsp_bus
);

   import pse_pkg::*;

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = $clog2(STACK_DEPTH);

   seq_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;
   op_type            op_ff, op_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CW-1:0]     rsp_depth_ff, rsp_depth_in;
   logic              rsp_final_ff, rsp_final_in;

   logic              accept;
   logic              slot_free;
   op_type            req_op;
   logic [CW-1:0]     count_m1;
   logic [CW-1:0]     count_m2;
   logic [DATA_W-1:0] top_or_zero;

   logic              ram_we;
   logic [DATA_W-1:0] ram_rdata;
   alu_cmd_type       alu_cmd;
   alu_rsp_type       alu_rsp;

   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == SEQ_IDLE) && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_op        = op_type'(req_bus.operation);
   assign count_m1      = count_ff - CW'(1);
   assign count_m2      = count_ff - CW'(2);
   assign top_or_zero   = (count_ff != '0) ? top_ff : '0;

   pse_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_m1[AW-1:0]),
      .wr_data (top_ff),
      .rd_addr (count_m2[AW-1:0]),
      .rd_data (ram_rdata)
   );

   pse_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .a     (ram_rdata),
      .b     (top_ff),
      .rsp   (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      op_ff         <= op_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_final_ff  <= rsp_final_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_final_in  = rsp_final_ff;
      ram_we        = 1'b0;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = op_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_final_in  = 1'b0;
               rsp_top_in    = top_or_zero;
               rsp_depth_in  = count_ff;
               case (req_op)
                  OP_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_we       = (count_ff != '0);
                        top_in       = req_bus.number;
                        count_in     = count_ff + CW'(1);
                        rsp_top_in   = req_bus.number;
                        rsp_depth_in = count_ff + CW'(1);
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (count_ff < CW'(2)) begin
                        rsp_status_in = ST_UNDER;
                     end else if (req_op == OP_DIV && top_ff == '0) begin
                        rsp_status_in = ST_DIVZ;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = SEQ_READ;
                     end
                  end
                  OP_END: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_UNDER;
                     end else begin
                        rsp_final_in = 1'b1;
                        rsp_depth_in = '0;
                        count_in     = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_READ: begin
            alu_cmd.start = 1'b1;
            state_in      = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (alu_rsp.done) begin
               top_in        = alu_rsp.result;
               count_in      = count_m1;
               rsp_valid_in  = 1'b1;
               rsp_top_in    = alu_rsp.result;
               rsp_status_in = ST_OK;
               rsp_depth_in  = count_m1;
               rsp_final_in  = 1'b0;
               state_in      = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.top_value   = rsp_top_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.stack_depth = DEPTH_W'(rsp_depth_ff);
   assign rsp_bus.final_res   = rsp_final_ff;

endmodule

`default_nettype wire
